/* hdl/usv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Shared constants, the arctangent table and the transaction types that
// travel along the divider and CORDIC chains.
// ----------------------------------------------------------------------------
package usv_pkg;

   localparam int MAX_SEGMENTS  = 256;
   localparam int SEG_W         = $clog2(MAX_SEGMENTS + 1);
   localparam int DIV_STEPS     = 32;
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_LEN      = 24;
   localparam int IDX_W         = 17;

   localparam logic [1:0] CSR_LAT_SEGMENTS  = 2'd0;
   localparam logic [1:0] CSR_LON_SEGMENTS  = 2'd1;
   localparam logic [1:0] CSR_SPHERE_RADIUS = 2'd2;

   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

   localparam logic [29:0] ATAN_TABLE [ATAN_LEN] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
      30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
   };

   typedef struct packed {
      logic             cell_valid;
      logic [IDX_W-1:0] first_index;
      logic [IDX_W-1:0] second_index;
   } side_type;

   typedef struct packed {
      logic                 valid;
      logic [SEG_W-1:0]     rem_t;
      logic [SEG_W-1:0]     rem_p;
      logic [DIV_STEPS-1:0] quo_t;
      logic [DIV_STEPS-1:0] quo_p;
      logic                 int_t;
      side_type             side;
   } div_type;

   typedef struct packed {
      logic               valid;
      logic signed [32:0] x_t;
      logic signed [32:0] y_t;
      logic signed [31:0] z_t;
      logic [1:0]         quad_t;
      logic signed [32:0] x_p;
      logic signed [32:0] y_p;
      logic signed [31:0] z_p;
      logic [1:0]         quad_p;
      side_type           side;
   } cordic_type;

endpackage

/* hdl/uv_sphere_vertex_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Position, unit normal and cell indices for one grid point of a UV sphere.
// ----------------------------------------------------------------------------
// The block is fully pipelined and takes one grid point per clock unless a
// result is stalled at the output: a transaction is loaded into the first of
// 51 register stages at the edge where req_ accepts it and reaches rsp_ through
// 32 divider cells, 16 CORDIC cells, two multiplier stages and the output
// register. The pipeline holds as a whole while a finished result is stalled
// at the output, so throughput is one transaction per cycle whenever
// rsp_stall is low. The angles are found by a chain of restoring divider
// cells, one quotient bit per cell, which divide the step by the segment
// count; sine and cosine then come from a chain of CORDIC cells that rotate
// the theta and phi vectors side by side. Segment counts of zero act as one
// and counts above 256 act as 256; steps above the count saturate to it. The
// user must write configuration through csr_ only while no transaction is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [8:0]                req_lat_step,
   input  logic [8:0]                req_lon_step,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [16:0]        rsp_pos_x,
   output logic signed [16:0]        rsp_pos_y,
   output logic signed [16:0]        rsp_pos_z,
   output logic signed [15:0]        rsp_norm_x,
   output logic signed [15:0]        rsp_norm_y,
   output logic signed [15:0]        rsp_norm_z,
   output logic                      rsp_cell_valid,
   output logic [16:0]               rsp_first_index,
   output logic [16:0]               rsp_second_index
);
   import usv_pkg::*;

   // Configuration registers.
   logic [8:0]  lat_seg_ff, lon_seg_ff;
   logic [15:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_seg_ff <= 9'd16;
         lon_seg_ff <= 9'd32;
         radius_ff  <= 16'd256;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LAT_SEGMENTS:  lat_seg_ff <= csr_data[8:0];
            CSR_LON_SEGMENTS:  lon_seg_ff <= csr_data[8:0];
            CSR_SPHERE_RADIUS: radius_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective segment counts: zero acts as one, large values clamp.
   logic [SEG_W-1:0] nl, nm;

   always_comb begin
      if (lat_seg_ff == '0) begin
         nl = SEG_W'(1);
      end else if (lat_seg_ff > 9'(MAX_SEGMENTS)) begin
         nl = SEG_W'(MAX_SEGMENTS);
      end else begin
         nl = SEG_W'(lat_seg_ff);
      end
      if (lon_seg_ff == '0) begin
         nm = SEG_W'(1);
      end else if (lon_seg_ff > 9'(MAX_SEGMENTS)) begin
         nm = SEG_W'(MAX_SEGMENTS);
      end else begin
         nm = SEG_W'(lon_seg_ff);
      end
   end

   // The whole pipeline moves unless a finished result is held at the output.
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Front logic: saturate steps, split off the integer quotient bit and
   // form the cell indices. The first divider cell registers all of it.
   logic [SEG_W-1:0] lat_sat, lon_sat;
   logic             int_t, int_p;
   logic [IDX_W-1:0] first_idx;
   logic             cell_ok;
   div_type          div_chain [DIV_STEPS+1];

   always_comb begin
      lat_sat = (SEG_W'(req_lat_step) > nl) ? nl : SEG_W'(req_lat_step);
      lon_sat = (SEG_W'(req_lon_step) > nm) ? nm : SEG_W'(req_lon_step);
      int_t   = lat_sat >= nl;
      int_p   = lon_sat >= nm;
      cell_ok = !int_t && !int_p;
      first_idx = IDX_W'(lat_sat) * IDX_W'({1'b0, nm} + 10'd1) + IDX_W'(lon_sat);

      div_chain[0].valid = req_valid;
      // A step equal to its count leaves no remainder.
      div_chain[0].rem_t = int_t ? '0 : lat_sat;
      div_chain[0].rem_p = int_p ? '0 : lon_sat;
      div_chain[0].quo_t = '0;
      div_chain[0].quo_p = '0;
      div_chain[0].int_t = int_t;
      div_chain[0].side.cell_valid   = cell_ok;
      div_chain[0].side.first_index  = first_idx;
      div_chain[0].side.second_index =
         cell_ok ? first_idx + IDX_W'(nm) + IDX_W'(1) : '0;
   end

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      usv_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .div_lat  (nl),
         .div_lon  (nm),
         .cell_in  (div_chain[i]),
         .cell_out (div_chain[i+1])
      );
   end

   // Angles as fractions of a full turn. Theta covers at most a half turn, so
   // its integer bit lands on bit 31; phi wraps modulo a full turn.
   logic [31:0] theta, phi;
   cordic_type  cor_chain [CORDIC_STAGES+1];

   always_comb begin
      theta = {div_chain[DIV_STEPS].int_t, div_chain[DIV_STEPS].quo_t[DIV_STEPS-1:1]};
      phi   = div_chain[DIV_STEPS].quo_p;

      cor_chain[0].valid  = div_chain[DIV_STEPS].valid;
      cor_chain[0].x_t    = CORDIC_GAIN;
      cor_chain[0].y_t    = '0;
      cor_chain[0].z_t    = signed'({2'b00, theta[29:0]});
      cor_chain[0].quad_t = theta[31:30];
      cor_chain[0].x_p    = CORDIC_GAIN;
      cor_chain[0].y_p    = '0;
      cor_chain[0].z_p    = signed'({2'b00, phi[29:0]});
      cor_chain[0].quad_p = phi[31:30];
      cor_chain[0].side   = div_chain[DIV_STEPS].side;
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      usv_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .stage_idx (5'(i)),
         .cell_in   (cor_chain[i]),
         .cell_out  (cor_chain[i+1])
      );
   end

   // Quadrant fold-back of the CORDIC results.
   logic signed [31:0] ct, st, cp, sp;
   cordic_type         cor_last;

   assign cor_last = cor_chain[CORDIC_STAGES];

   always_comb begin
      case (cor_last.quad_t)
         2'd0: begin
            ct = 32'(cor_last.x_t);
            st = 32'(cor_last.y_t);
         end
         2'd1: begin
            ct = 32'(-cor_last.y_t);
            st = 32'(cor_last.x_t);
         end
         2'd2: begin
            ct = 32'(-cor_last.x_t);
            st = 32'(-cor_last.y_t);
         end
         default: begin
            ct = 32'(cor_last.y_t);
            st = 32'(-cor_last.x_t);
         end
      endcase
      case (cor_last.quad_p)
         2'd0: begin
            cp = 32'(cor_last.x_p);
            sp = 32'(cor_last.y_p);
         end
         2'd1: begin
            cp = 32'(-cor_last.y_p);
            sp = 32'(cor_last.x_p);
         end
         2'd2: begin
            cp = 32'(-cor_last.x_p);
            sp = 32'(-cor_last.y_p);
         end
         default: begin
            cp = 32'(cor_last.y_p);
            sp = 32'(-cor_last.x_p);
         end
      endcase
   end

   // First multiplier stage: cos(phi)*sin(theta) and sin(phi)*sin(theta).
   logic               m1_valid_ff;
   logic signed [63:0] prod_x_ff, prod_z_ff;
   logic signed [31:0] dy_m1_ff;
   side_type           side_m1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff <= cor_last.valid;
      end
      if (adv) begin
         prod_x_ff  <= cp * st;
         prod_z_ff  <= sp * st;
         dy_m1_ff   <= ct;
         side_m1_ff <= cor_last.side;
      end
   end

   // Second stage: round the direction to Q30, scale by the radius and
   // round the normal to Q15.
   logic signed [63:0] rnd_x, rnd_z;
   logic signed [31:0] dx, dz;
   logic signed [16:0] rad_s;

   always_comb begin
      rnd_x = (prod_x_ff + 64'sd536870912) >>> 30;
      rnd_z = (prod_z_ff + 64'sd536870912) >>> 30;
      dx    = 32'(rnd_x);
      dz    = 32'(rnd_z);
      rad_s = signed'({1'b0, radius_ff});
   end

   function automatic logic signed [15:0] to_norm(input logic signed [31:0] d);
      logic signed [32:0] v;
      v = (33'(d) + 33'sd16384) >>> 15;
      if (v > 33'sd32767) begin
         return 16'sd32767;
      end else if (v < -33'sd32768) begin
         return -16'sd32768;
      end
      return 16'(v);
   endfunction

   logic               m2_valid_ff;
   logic signed [48:0] pprod_x_ff, pprod_y_ff, pprod_z_ff;
   logic signed [15:0] nx_m2_ff, ny_m2_ff, nz_m2_ff;
   side_type           side_m2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (adv) begin
         m2_valid_ff <= m1_valid_ff;
      end
      if (adv) begin
         pprod_x_ff <= dx * rad_s;
         pprod_y_ff <= dy_m1_ff * rad_s;
         pprod_z_ff <= dz * rad_s;
         nx_m2_ff   <= to_norm(dx);
         ny_m2_ff   <= to_norm(dy_m1_ff);
         nz_m2_ff   <= to_norm(dz);
         side_m2_ff <= side_m1_ff;
      end
   end

   function automatic logic signed [16:0] to_pos(input logic signed [48:0] p);
      logic signed [48:0] v;
      v = (p + 49'sd536870912) >>> 30;
      if (v > 49'sd65535) begin
         return 17'sd65535;
      end else if (v < -49'sd65535) begin
         return -17'sd65535;
      end
      return 17'(v);
   endfunction

   // Output register.
   logic signed [16:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [15:0] norm_x_ff, norm_y_ff, norm_z_ff;
   side_type           side_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= m2_valid_ff;
      end
      if (adv) begin
         pos_x_ff    <= to_pos(pprod_x_ff);
         pos_y_ff    <= to_pos(pprod_y_ff);
         pos_z_ff    <= to_pos(pprod_z_ff);
         norm_x_ff   <= nx_m2_ff;
         norm_y_ff   <= ny_m2_ff;
         norm_z_ff   <= nz_m2_ff;
         side_out_ff <= side_m2_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = pos_x_ff;
   assign rsp_pos_y        = pos_y_ff;
   assign rsp_pos_z        = pos_z_ff;
   assign rsp_norm_x       = norm_x_ff;
   assign rsp_norm_y       = norm_y_ff;
   assign rsp_norm_z       = norm_z_ff;
   assign rsp_cell_valid   = side_out_ff.cell_valid;
   assign rsp_first_index  = side_out_ff.first_index;
   assign rsp_second_index = side_out_ff.second_index;

endmodule

/* hdl/usv_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere divider cell
// One restoring step of the two angle divisions, one quotient bit each.
// ----------------------------------------------------------------------------
module usv_div_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [usv_pkg::SEG_W-1:0]     div_lat,
   input  logic [usv_pkg::SEG_W-1:0]     div_lon,
   input  usv_pkg::div_type              cell_in,
   output usv_pkg::div_type              cell_out
);
   import usv_pkg::*;

   logic [SEG_W:0]   dbl_t, dbl_p;
   logic             bit_t, bit_p;
   div_type          cell_in_d;
   div_type          cell_ff;

   always_comb begin
      dbl_t = {cell_in.rem_t, 1'b0};
      dbl_p = {cell_in.rem_p, 1'b0};
      bit_t = dbl_t >= {1'b0, div_lat};
      bit_p = dbl_p >= {1'b0, div_lon};
      cell_in_d = cell_in;
      cell_in_d.rem_t = bit_t ? SEG_W'(dbl_t - {1'b0, div_lat}) : SEG_W'(dbl_t);
      cell_in_d.rem_p = bit_p ? SEG_W'(dbl_p - {1'b0, div_lon}) : SEG_W'(dbl_p);
      cell_in_d.quo_t = {cell_in.quo_t[DIV_STEPS-2:0], bit_t};
      cell_in_d.quo_p = {cell_in.quo_p[DIV_STEPS-2:0], bit_p};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else if (adv) begin
         cell_ff <= cell_in_d;
      end
   end

   assign cell_out = cell_ff;

endmodule

/* hdl/usv_cordic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere CORDIC cell
// One rotation step for the theta and the phi vector side by side.
// ----------------------------------------------------------------------------
module usv_cordic_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic [4:0]           stage_idx,
   input  usv_pkg::cordic_type  cell_in,
   output usv_pkg::cordic_type  cell_out
);
   import usv_pkg::*;

   logic signed [31:0] atan_s;
   cordic_type         cell_in_d;
   cordic_type         cell_ff;

   always_comb begin
      atan_s = signed'({2'b00, ATAN_TABLE[stage_idx]});
      cell_in_d = cell_in;
      if (cell_in.z_t >= 0) begin
         cell_in_d.x_t = cell_in.x_t - (cell_in.y_t >>> stage_idx);
         cell_in_d.y_t = cell_in.y_t + (cell_in.x_t >>> stage_idx);
         cell_in_d.z_t = cell_in.z_t - atan_s;
      end else begin
         cell_in_d.x_t = cell_in.x_t + (cell_in.y_t >>> stage_idx);
         cell_in_d.y_t = cell_in.y_t - (cell_in.x_t >>> stage_idx);
         cell_in_d.z_t = cell_in.z_t + atan_s;
      end
      if (cell_in.z_p >= 0) begin
         cell_in_d.x_p = cell_in.x_p - (cell_in.y_p >>> stage_idx);
         cell_in_d.y_p = cell_in.y_p + (cell_in.x_p >>> stage_idx);
         cell_in_d.z_p = cell_in.z_p - atan_s;
      end else begin
         cell_in_d.x_p = cell_in.x_p + (cell_in.y_p >>> stage_idx);
         cell_in_d.y_p = cell_in.y_p - (cell_in.x_p >>> stage_idx);
         cell_in_d.z_p = cell_in.z_p + atan_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else if (adv) begin
         cell_ff <= cell_in_d;
      end
   end

   assign cell_out = cell_ff;

endmodule

/* bench/uv_sphere_vertex_generator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator testbench
// Drives grid points into the generator under several segment and radius
// settings and compares every vertex against a bit-true model of the angle
// division, the CORDIC, the rounding and the cell index logic.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_tb;
   import usv_pkg::*;

   localparam int          HALF_HIGH    = 6;
   localparam int          HALF_LOW     = 6;
   localparam int          RESET_CYCLES = 7;
   localparam int          PHASES       = 8;
   localparam int          PHASE_ITEMS  = 116;
   localparam int          GRID_ROWS    = 18;
   localparam int          IDLE_LIMIT   = 3000;
   // The pipeline has 51 register stages; settle a little longer than that.
   localparam int          SETTLE       = 64;
   localparam logic [1:0]  CSR_UNUSED   = 2'd3;
   localparam longint      Q30_HALF     = 64'sd536870912;

   // One vertex as the block should deliver it.
   typedef struct {
      logic signed [16:0] pos_x, pos_y, pos_z;
      logic signed [15:0] norm_x, norm_y, norm_z;
      logic               cell_valid;
      logic [16:0]        first_index, second_index;
   } vertex_type;

   // A directed grid point. Where fixed is set, the cell fields are typed in.
   typedef struct packed {
      logic [8:0]  lat, lon;
      logic        fixed;
      logic        cell_valid;
      logic [16:0] first_index, second_index;
   } grid_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [8:0]         req_lat_step = '0;
   logic [8:0]         req_lon_step = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [16:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic               rsp_cell_valid;
   logic [16:0]        rsp_first_index, rsp_second_index;

   uv_sphere_vertex_generator dut (.*);

   always begin
      #HALF_HIGH clock = 1'b1;
      #HALF_LOW  clock = 1'b0;
   end

   // Our own copy of the configuration registers.
   logic [8:0]  lat_segs_reg = 9'd16;
   logic [8:0]  lon_segs_reg = 9'd32;
   logic [15:0] radius_reg   = 16'd256;

   vertex_type pending_vertices[$];
   int      mismatches = 0;
   int      points_sent = 0;
   int      vertices_seen = 0;
   int      idle_cycles = 0;
   bit      calm_output = 1'b0;

   // A segment count of zero acts as one, counts above the maximum clamp.
   function automatic longint segs_used(input logic [8:0] reg_value);
      if (reg_value == 0)
         return 1;
      return (reg_value > MAX_SEGMENTS) ? MAX_SEGMENTS : reg_value;
   endfunction

   // Rotation-mode CORDIC on a 32-bit fraction of a turn, results in Q2.30.
   function automatic void turn_sin_cos(input longint angle, output longint c,
                                        output longint s);
      longint x, y, z, dx, dy;
      logic [1:0] quad;
      x = CORDIC_GAIN;
      y = 0;
      z = angle & 64'h3FFF_FFFF;
      quad = angle[31:30];
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TABLE[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TABLE[i]);
         end
      end
      case (quad)
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic longint unit_to_q15(input longint d);
      longint v;
      v = (d + 16384) >>> 15;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   function automatic longint unit_to_pos(input longint d, input longint r);
      longint v;
      v = (d * r + Q30_HALF) >>> 30;
      if (v > 65535) v = 65535;
      if (v < -65535) v = -65535;
      return v;
   endfunction

   // Works out the vertex for one grid point under the current settings.
   function automatic vertex_type sphere_vertex(input logic [8:0] lat_in,
                                                input logic [8:0] lon_in);
      vertex_type v;
      longint nl, nm, lat, lon, theta, phi, ct, st, cp, sp, dx, dy, dz, first;
      nl = segs_used(lat_segs_reg);
      nm = segs_used(lon_segs_reg);
      lat = (lat_in > nl) ? nl : lat_in;
      lon = (lon_in > nm) ? nm : lon_in;
      theta = (lat << 31) / nl;
      phi = ((lon << 32) / nm) & 64'hFFFF_FFFF;
      turn_sin_cos(theta, ct, st);
      turn_sin_cos(phi, cp, sp);
      dx = (cp * st + Q30_HALF) >>> 30;
      dy = ct;
      dz = (sp * st + Q30_HALF) >>> 30;
      v.pos_x  = 17'(unit_to_pos(dx, radius_reg));
      v.pos_y  = 17'(unit_to_pos(dy, radius_reg));
      v.pos_z  = 17'(unit_to_pos(dz, radius_reg));
      v.norm_x = 16'(unit_to_q15(dx));
      v.norm_y = 16'(unit_to_q15(dy));
      v.norm_z = 16'(unit_to_q15(dz));
      v.cell_valid = (lat < nl) && (lon < nm);
      first = lat * (nm + 1) + lon;
      v.first_index  = 17'(first);
      v.second_index = v.cell_valid ? 17'(first + nm + 1) : 17'd0;
      return v;
   endfunction

   task automatic report(input string field, input longint got, input longint want);
      mismatches++;
      $display("mismatch at %0t on %s: got %0d, expected %0d", $realtime, field, got,
               want);
   endtask

   // Output side: check each accepted transaction against the oldest expected
   // vertex.
   always @(posedge clock) begin
      vertex_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         vertices_seen++;
         if (pending_vertices.size() == 0) begin
            report("unexpected vertex", 1, 0);
         end else begin
            want = pending_vertices.pop_front();
            if (rsp_pos_x !== want.pos_x) report("pos_x", rsp_pos_x, want.pos_x);
            if (rsp_pos_y !== want.pos_y) report("pos_y", rsp_pos_y, want.pos_y);
            if (rsp_pos_z !== want.pos_z) report("pos_z", rsp_pos_z, want.pos_z);
            if (rsp_norm_x !== want.norm_x) report("norm_x", rsp_norm_x, want.norm_x);
            if (rsp_norm_y !== want.norm_y) report("norm_y", rsp_norm_y, want.norm_y);
            if (rsp_norm_z !== want.norm_z) report("norm_z", rsp_norm_z, want.norm_z);
            if (rsp_cell_valid !== want.cell_valid)
               report("cell_valid", rsp_cell_valid, want.cell_valid);
            if (rsp_first_index !== want.first_index)
               report("first_index", rsp_first_index, want.first_index);
            if (rsp_second_index !== want.second_index)
               report("second_index", rsp_second_index, want.second_index);
         end
      end
   end

   // Output back-pressure: mostly short stalls, now and then a long one, and
   // stretches with none at all while calm_output is set.
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!calm_output && $urandom_range(0, 3) == 0) begin
         stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: any accepted transaction on either side restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d quiet cycles", idle_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Presents one grid point and holds it until accepted. The expectation is
   // queued at the edge where the transaction is taken.
   task automatic send_point(input logic [8:0] lat, input logic [8:0] lon,
                             input bit fixed_cell, input grid_row_type row);
      vertex_type want;
      req_valid <= 1'b1;
      req_lat_step <= lat;
      req_lon_step <= lon;
      do
         @(posedge clock);
      while (req_stall);
      want = sphere_vertex(lat, lon);
      if (fixed_cell) begin
         want.cell_valid = row.cell_valid;
         want.first_index = row.first_index;
         want.second_index = row.second_index;
      end
      pending_vertices = {pending_vertices, want};
      points_sent++;
   endtask

   // Input gap: usually none, sometimes short, rarely long.
   task automatic input_gap(input bit calm);
      int n, pick;
      pick = $urandom_range(0, 99);
      if (calm || pick < 65)
         n = 0;
      else if (pick < 95)
         n = $urandom_range(1, 3);
      else
         n = $urandom_range(10, 60);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Lower valid, let every expected vertex come back and the pipeline go
   // quiet, so the settings can change safely.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_vertices.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         CSR_LAT_SEGMENTS:  lat_segs_reg = value[8:0];
         CSR_LON_SEGMENTS:  lon_segs_reg = value[8:0];
         CSR_SPHERE_RADIUS: radius_reg = value;
         default: ;
      endcase
   endtask

   // Directed points under the reset settings (16 bands, 32 slices, radius 256).
   // Cell fields are typed in where they follow directly from the grid size.
   grid_row_type grid_rows[GRID_ROWS] = '{
      '{9'd0,   9'd0,   1'b1, 1'b1, 17'd0,   17'd33},
      '{9'd16,  9'd0,   1'b1, 1'b0, 17'd528, 17'd0},
      '{9'd15,  9'd31,  1'b1, 1'b1, 17'd526, 17'd559},
      '{9'd0,   9'd32,  1'b1, 1'b0, 17'd32,  17'd0},
      '{9'd16,  9'd32,  1'b1, 1'b0, 17'd560, 17'd0},
      '{9'd511, 9'd511, 1'b1, 1'b0, 17'd560, 17'd0},
      '{9'd17,  9'd3,   1'b1, 1'b0, 17'd531, 17'd0},
      '{9'd256, 9'd256, 1'b1, 1'b0, 17'd560, 17'd0},
      '{9'd8,   9'd0,   1'b0, 1'b0, 17'd0,   17'd0},
      '{9'd8,   9'd8,   1'b0, 1'b0, 17'd0,   17'd0},
      '{9'd8,   9'd16,  1'b0, 1'b0, 17'd0,   17'd0},
      '{9'd8,   9'd24,  1'b0, 1'b0, 17'd0,   17'd0},
      '{9'd4,   9'd4,   1'b0, 1'b0, 17'd0,   17'd0},
      '{9'd12,  9'd20,  1'b0, 1'b0, 17'd0,   17'd0},
      '{9'd1,   9'd1,   1'b0, 1'b0, 17'd0,   17'd0},
      '{9'd15,  9'd17,  1'b0, 1'b0, 17'd0,   17'd0},
      '{9'd170, 9'd341, 1'b0, 1'b0, 17'd0,   17'd0},
      '{9'd341, 9'd170, 1'b0, 1'b0, 17'd0,   17'd0}
   };

   // Settings per random phase: the extremes first, then random ones. A count
   // of zero acts as one and counts above 256 clamp.
   logic [15:0] phase_lat[PHASES]    = '{16'd256, 16'd1, 16'd0,   16'd300,
                                         16'd511, 16'd7, 16'd0,   16'd0};
   logic [15:0] phase_lon[PHASES]    = '{16'd256, 16'd1, 16'd0,   16'd511,
                                         16'd300, 16'd13, 16'd0,  16'd0};
   logic [15:0] phase_radius[PHASES] = '{16'hFFFF, 16'd0, 16'd1, 16'hFFFF,
                                         16'h8000, 16'd0, 16'd0, 16'd0};

   initial begin
      longint nl, nm;
      logic [8:0] lat, lon;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (grid_rows[i]) begin
         send_point(grid_rows[i].lat, grid_rows[i].lon, grid_rows[i].fixed,
                    grid_rows[i]);
         input_gap(1'b0);
      end

      for (int p = 0; p < PHASES; p++) begin
         // The sender waits here until every vertex in flight has returned.
         drain();
         if (p >= 6) begin
            phase_lat[p] = 16'($urandom_range(1, 256));
            phase_lon[p] = 16'($urandom_range(1, 256));
            phase_radius[p] = 16'($urandom_range(0, 65535));
         end
         write_reg(CSR_LAT_SEGMENTS, phase_lat[p]);
         write_reg(CSR_LON_SEGMENTS, phase_lon[p]);
         write_reg(CSR_SPHERE_RADIUS, phase_radius[p]);
         // An unused index must leave every register as it was.
         if (p == 2) write_reg(CSR_UNUSED, 16'hFFFF);
         csr_write_enable <= 1'b0;
         calm_output = (p % 3 == 1);
         nl = segs_used(lat_segs_reg);
         nm = segs_used(lon_segs_reg);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Mostly points on the grid or on its edge, some anywhere.
            if ($urandom_range(0, 7) == 0) begin
               lat = 9'($urandom_range(0, 511));
               lon = 9'($urandom_range(0, 511));
            end else begin
               lat = 9'($urandom_range(0, int'(nl)));
               lon = 9'($urandom_range(0, int'(nm)));
            end
            send_point(lat, lon, 1'b0, grid_rows[0]);
            input_gap(calm_output && n < PHASE_ITEMS / 2);
         end
      end

      drain();
      $display("covered %0d grid points over %0d settings, %0d vertices checked",
               points_sent, PHASES + 1, vertices_seen);
      $display("mismatching fields: %0d", mismatches + pending_vertices.size());
      if (mismatches == 0 && pending_vertices.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* uv_sphere_vertex_generator.f */
hdl/usv_pkg.sv
hdl/usv_div_cell.sv
hdl/usv_cordic_cell.sv
hdl/uv_sphere_vertex_generator.sv
bench/uv_sphere_vertex_generator_tb.sv
